/* rtl/segment_segment_closest_distance_defines.svh */
// ---------------------------------------------------------------------------
// segment_segment_closest_distance_defines
// shared assertion macros, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef SEGMENT_SEGMENT_CLOSEST_DISTANCE_DEFINES_SVH
`define SEGMENT_SEGMENT_CLOSEST_DISTANCE_DEFINES_SVH

// same-cycle implication
`define SSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ssd_pkg.sv */
// ---------------------------------------------------------------------------
// ssd_pkg
// fixed widths and types shared by the closest-distance block
// ---------------------------------------------------------------------------
package ssd_pkg;

  localparam int OUT_W = 52;
  localparam int THR_W = 20;

  typedef logic [OUT_W-1:0] dist_t;
  typedef logic [THR_W-1:0] thr_t;

endpackage

/* rtl/ssd_ifs.sv */
// ---------------------------------------------------------------------------
// ssd_ifs
// valid/ready channels: segment pair request, distance result, threshold write
// ---------------------------------------------------------------------------
interface ssd_in_if #(parameter int CB = 24) ();
  logic valid;
  logic ready;
  logic signed [CB-1:0] first_far_x;
  logic signed [CB-1:0] first_far_y;
  logic signed [CB-1:0] first_far_z;
  logic signed [CB-1:0] first_base_x;
  logic signed [CB-1:0] first_base_y;
  logic signed [CB-1:0] first_base_z;
  logic signed [CB-1:0] second_far_x;
  logic signed [CB-1:0] second_far_y;
  logic signed [CB-1:0] second_far_z;
  logic signed [CB-1:0] second_base_x;
  logic signed [CB-1:0] second_base_y;
  logic signed [CB-1:0] second_base_z;

  modport source (
    output valid, first_far_x, first_far_y, first_far_z,
    output first_base_x, first_base_y, first_base_z,
    output second_far_x, second_far_y, second_far_z,
    output second_base_x, second_base_y, second_base_z,
    input  ready
  );
  modport sink (
    input  valid, first_far_x, first_far_y, first_far_z,
    input  first_base_x, first_base_y, first_base_z,
    input  second_far_x, second_far_y, second_far_z,
    input  second_base_x, second_base_y, second_base_z,
    output ready
  );
endinterface

interface ssd_out_if import ssd_pkg::*; ();
  logic  valid;
  logic  ready;
  dist_t squared_distance;

  modport source (output valid, squared_distance, input ready);
  modport sink (input valid, squared_distance, output ready);
endinterface

interface ssd_cfg_if import ssd_pkg::*; ();
  logic valid;
  logic ready;
  thr_t degenerate_threshold;

  modport source (output valid, degenerate_threshold, input ready);
  modport sink (input valid, degenerate_threshold, output ready);
endinterface

/* rtl/segment_segment_closest_distance.sv */
// ---------------------------------------------------------------------------
// segment_segment_closest_distance
// squared distance between the closest points of two 3d segments
// ---------------------------------------------------------------------------
// channel   dir  payload
// in_bus    in   twelve endpoint coordinates, signed q16.8
// out_bus   out  squared_distance, unsigned q36.16
// cfg_bus   in   degenerate_threshold
//
// one request per cycle, except while a held result stalls the pipeline
// the two fraction dividers are chained, one quotient bit per stage
// a held result with out_bus.ready low stalls every stage at once
// synchronous reset clears the valid bits and the threshold
// ---------------------------------------------------------------------------
`include "segment_segment_closest_distance_defines.svh"

module segment_segment_closest_distance import ssd_pkg::*; #(
  parameter int COORD_BITS      = 24,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  ssd_in_if.sink     in_bus,
  ssd_out_if.source  out_bus,
  ssd_cfg_if.sink    cfg_bus
);

  localparam int CB   = COORD_BITS;
  localparam int P    = PARAM_FRAC_BITS;
  localparam int DB   = CB + 1;
  localparam int PB   = 2 * DB;
  localparam int DW   = PB + 2;
  localparam int MW   = 2 * DW;
  localparam int NW   = MW + 1;
  localparam int AW   = DW + 1;
  localparam int TW   = DW + P + 3;
  localparam int SW   = P + 1;
  localparam int WW   = DB + P + 4;
  localparam int QW   = 2 * WW;
  localparam int ACW0 = QW + 2;
  localparam int ACWM = 2 * P + OUT_W + 1;
  localparam int ACW  = (ACW0 > ACWM) ? ACW0 : ACWM;
  localparam int L    = 17 + 2 * P;
  localparam int SEL  = 12 + 2 * P;
  localparam logic [SW-1:0] ONE = {1'b1, {P{1'b0}}};

  typedef struct packed {
    logic [2:0][DB-1:0] d1;
    logic [2:0][DB-1:0] d2;
    logic [2:0][DB-1:0] r;
  } geo_t;

  typedef struct packed {
    logic [2:0][PB-1:0] aa;
    logic [2:0][PB-1:0] ee;
    logic [2:0][PB-1:0] ff;
    logic [2:0][PB-1:0] cc;
    logic [2:0][PB-1:0] bb;
  } prd_t;

  typedef struct packed {
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] c;
    logic signed [DW-1:0] e;
    logic signed [DW-1:0] f;
  } dot_t;

  typedef struct packed {
    logic adeg;
    logic edeg;
  } flg_t;

  typedef struct packed {
    logic [SW-1:0] s_gen;
    logic [SW-1:0] s0;
    logic [SW-1:0] s1;
    logic [SW-1:0] t_ad;
    logic          dz;
  } frc_t;

  typedef struct packed {
    logic tneg;
    logic tbig;
  } tfl_t;

  logic         pipe_en;
  logic [L:1]   vld_r;
  thr_t         thr_r;

  geo_t geo_nxt;
  geo_t geo_d [12+2*P];
  prd_t prd_r;
  dot_t dot_nxt;
  dot_t dot_d [7+P];
  flg_t flg_d [8+2*P];
  logic dz_d  [P+2];
  frc_t frc_d [P+4];
  tfl_t tf_d  [P+2];

  logic signed [MW-1:0] ae_p, bb_p, bf_p, ce_p;
  logic signed [NW-1:0] denom_r, snum_r;
  logic signed [AW-1:0] negc_w, bmc_w, f_w, a_w, e_w;
  logic [SW-1:0]        sg_q, s0_q, s1_q, tad_q, tg_q;
  logic [SW-1:0]        s_used;
  logic signed [DW+SW:0] bs_p;
  logic signed [TW-1:0] tnum_nxt, esc_nxt, tnum_r, esc_r;

  logic [SW-1:0] s_sel, t_sel, s_gen_m, s_fin_r, t_fin_r;
  flg_t fl;
  frc_t fr;
  tfl_t tf;

  logic signed [DB+SW:0] ps_r [3];
  logic signed [DB+SW:0] pt_r [3];
  logic signed [DB-1:0]  rr_r [3];
  logic signed [WW-1:0]  w_r  [3];
  logic signed [QW-1:0]  sq   [3];
  logic [ACW-1:0]        acc;
  dist_t                 dist_r;

  assign pipe_en       = !vld_r[L] || out_bus.ready;
  assign in_bus.ready  = pipe_en;
  assign cfg_bus.ready = 1'b1;
  assign out_bus.valid = vld_r[L];
  assign out_bus.squared_distance = dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      thr_r <= '0;
    end else begin
      if (pipe_en) begin
        vld_r <= {vld_r[L-1:1], in_bus.valid};
      end
      if (cfg_bus.valid) begin
        thr_r <= cfg_bus.degenerate_threshold;
      end
    end
  end

  // differences
  always_comb begin
    geo_nxt.d1[0] = DB'(in_bus.first_far_x) - DB'(in_bus.first_base_x);
    geo_nxt.d1[1] = DB'(in_bus.first_far_y) - DB'(in_bus.first_base_y);
    geo_nxt.d1[2] = DB'(in_bus.first_far_z) - DB'(in_bus.first_base_z);
    geo_nxt.d2[0] = DB'(in_bus.second_far_x) - DB'(in_bus.second_base_x);
    geo_nxt.d2[1] = DB'(in_bus.second_far_y) - DB'(in_bus.second_base_y);
    geo_nxt.d2[2] = DB'(in_bus.second_far_z) - DB'(in_bus.second_base_z);
    geo_nxt.r[0]  = DB'(in_bus.first_base_x) - DB'(in_bus.second_base_x);
    geo_nxt.r[1]  = DB'(in_bus.first_base_y) - DB'(in_bus.second_base_y);
    geo_nxt.r[2]  = DB'(in_bus.first_base_z) - DB'(in_bus.second_base_z);
  end

  // dot product sums
  always_comb begin
    dot_nxt.a = '0;
    dot_nxt.b = '0;
    dot_nxt.c = '0;
    dot_nxt.e = '0;
    dot_nxt.f = '0;
    for (int k = 0; k < 3; k++) begin
      dot_nxt.a = dot_nxt.a + DW'($signed(prd_r.aa[k]));
      dot_nxt.b = dot_nxt.b + DW'($signed(prd_r.bb[k]));
      dot_nxt.c = dot_nxt.c + DW'($signed(prd_r.cc[k]));
      dot_nxt.e = dot_nxt.e + DW'($signed(prd_r.ee[k]));
      dot_nxt.f = dot_nxt.f + DW'($signed(prd_r.ff[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      geo_d[0] <= geo_nxt;
      for (int i = 1; i < 12 + 2 * P; i++) begin
        geo_d[i] <= geo_d[i-1];
      end
      for (int k = 0; k < 3; k++) begin
        prd_r.aa[k] <= PB'($signed(geo_d[0].d1[k]) * $signed(geo_d[0].d1[k]));
        prd_r.ee[k] <= PB'($signed(geo_d[0].d2[k]) * $signed(geo_d[0].d2[k]));
        prd_r.ff[k] <= PB'($signed(geo_d[0].d2[k]) * $signed(geo_d[0].r[k]));
        prd_r.cc[k] <= PB'($signed(geo_d[0].d1[k]) * $signed(geo_d[0].r[k]));
        prd_r.bb[k] <= PB'($signed(geo_d[0].d1[k]) * $signed(geo_d[0].d2[k]));
      end
      dot_d[0] <= dot_nxt;
      for (int i = 1; i < 7 + P; i++) begin
        dot_d[i] <= dot_d[i-1];
      end
      flg_d[0].adeg <= dot_d[0].a <= $signed(DW'({1'b0, thr_r}));
      flg_d[0].edeg <= dot_d[0].e <= $signed(DW'({1'b0, thr_r}));
      for (int i = 1; i < 8 + 2 * P; i++) begin
        flg_d[i] <= flg_d[i-1];
      end
    end
  end

  // denominator and general s numerator
  ssd_mul #(.WA(DW), .WB(DW)) u_mul_ae (
    .clk(clk), .en(pipe_en), .a(dot_d[0].a), .b(dot_d[0].e), .prod(ae_p)
  );
  ssd_mul #(.WA(DW), .WB(DW)) u_mul_bb (
    .clk(clk), .en(pipe_en), .a(dot_d[0].b), .b(dot_d[0].b), .prod(bb_p)
  );
  ssd_mul #(.WA(DW), .WB(DW)) u_mul_bf (
    .clk(clk), .en(pipe_en), .a(dot_d[0].b), .b(dot_d[0].f), .prod(bf_p)
  );
  ssd_mul #(.WA(DW), .WB(DW)) u_mul_ce (
    .clk(clk), .en(pipe_en), .a(dot_d[0].c), .b(dot_d[0].e), .prod(ce_p)
  );

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      denom_r <= NW'(ae_p) - NW'(bb_p);
      snum_r  <= NW'(bf_p) - NW'(ce_p);
      dz_d[0] <= (ae_p == bb_p);
      for (int i = 1; i < P + 2; i++) begin
        dz_d[i] <= dz_d[i-1];
      end
    end
  end

  assign negc_w = -AW'(dot_d[3].c);
  assign bmc_w  = AW'(dot_d[3].b) - AW'(dot_d[3].c);
  assign a_w    = AW'(dot_d[3].a);
  assign e_w    = AW'(dot_d[3].e);
  assign f_w    = AW'(dot_d[3].f);

  ssd_div #(.W(NW), .P(P)) u_div_sg (
    .clk(clk), .en(pipe_en), .num(snum_r), .den(denom_r), .quo(sg_q)
  );
  ssd_div #(.W(AW), .P(P)) u_div_s0 (
    .clk(clk), .en(pipe_en), .num(negc_w), .den(a_w), .quo(s0_q)
  );
  ssd_div #(.W(AW), .P(P)) u_div_s1 (
    .clk(clk), .en(pipe_en), .num(bmc_w), .den(a_w), .quo(s1_q)
  );
  ssd_div #(.W(AW), .P(P)) u_div_tad (
    .clk(clk), .en(pipe_en), .num(f_w), .den(e_w), .quo(tad_q)
  );

  // t numerator b*s + f*2^P
  assign s_used = dz_d[P+1] ? '0 : sg_q;

  ssd_mul #(.WA(DW), .WB(SW+1)) u_mul_bs (
    .clk(clk), .en(pipe_en), .a(dot_d[4+P].b), .b($signed({1'b0, s_used})), .prod(bs_p)
  );

  assign tnum_nxt = TW'(bs_p) + (TW'(dot_d[6+P].f) <<< P);
  assign esc_nxt  = TW'(dot_d[6+P].e) <<< P;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      frc_d[0].s_gen <= sg_q;
      frc_d[0].s0    <= s0_q;
      frc_d[0].s1    <= s1_q;
      frc_d[0].t_ad  <= tad_q;
      frc_d[0].dz    <= dz_d[P+1];
      for (int i = 1; i < P + 4; i++) begin
        frc_d[i] <= frc_d[i-1];
      end
      tnum_r       <= tnum_nxt;
      esc_r        <= esc_nxt;
      tf_d[0].tneg <= tnum_nxt[TW-1];
      tf_d[0].tbig <= tnum_nxt > esc_nxt;
      for (int i = 1; i < P + 2; i++) begin
        tf_d[i] <= tf_d[i-1];
      end
    end
  end

  ssd_div #(.W(TW), .P(P)) u_div_tg (
    .clk(clk), .en(pipe_en), .num(tnum_r), .den(esc_r), .quo(tg_q)
  );

  // case selection of s and t
  assign fl = flg_d[7+2*P];
  assign fr = frc_d[P+3];
  assign tf = tf_d[P+1];

  always_comb begin
    s_sel   = '0;
    t_sel   = '0;
    s_gen_m = fr.dz ? '0 : fr.s_gen;
    if (fl.adeg && fl.edeg) begin
      s_sel = '0;
    end else if (fl.adeg) begin
      t_sel = fr.t_ad;
    end else if (fl.edeg) begin
      s_sel = fr.s0;
    end else if (tf.tneg) begin
      s_sel = fr.s0;
    end else if (tf.tbig) begin
      s_sel = fr.s1;
      t_sel = ONE;
    end else begin
      s_sel = s_gen_m;
      t_sel = tg_q;
    end
  end

  // closest point difference
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s_fin_r <= s_sel;
      t_fin_r <= t_sel;
      for (int k = 0; k < 3; k++) begin
        ps_r[k] <= (DB+SW+1)'($signed(geo_d[11+2*P].d1[k]) * $signed({1'b0, s_fin_r}));
        pt_r[k] <= (DB+SW+1)'($signed(geo_d[11+2*P].d2[k]) * $signed({1'b0, t_fin_r}));
        rr_r[k] <= $signed(geo_d[11+2*P].r[k]);
        w_r[k]  <= (WW'(rr_r[k]) <<< P) + WW'(ps_r[k]) - WW'(pt_r[k]);
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_sq
    ssd_mul #(.WA(WW), .WB(WW)) u_mul_sq (
      .clk(clk), .en(pipe_en), .a(w_r[k]), .b(w_r[k]), .prod(sq[k])
    );
  end

  assign acc = ACW'(sq[0]) + ACW'(sq[1]) + ACW'(sq[2]);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      if (|acc[ACW-1:2*P+OUT_W]) begin
        dist_r <= '1;
      end else begin
        dist_r <= acc[2*P+OUT_W-1:2*P];
      end
    end
  end

  `SSD_ASSERT_NEXT(a_stall_hold, !pipe_en, $stable(vld_r), "pipeline advanced while stalled")
  `SSD_ASSERT_NEXT(a_enter, in_bus.valid && in_bus.ready, vld_r[1], "accepted request lost")
  `SSD_ASSERT_IMP(a_frac_range, vld_r[SEL], s_fin_r <= ONE && t_fin_r <= ONE, "fraction above one")
  `SSD_ASSERT_NEXT(a_point_pair, pipe_en && vld_r[SEL-1] && fl.adeg && fl.edeg, s_fin_r == '0 && t_fin_r == '0, "point pair fractions not zero")

endmodule

/* rtl/ssd_mul.sv */
// ---------------------------------------------------------------------------
// ssd_mul
// signed multiplier, split in half-width partial products, two stages
// ---------------------------------------------------------------------------
module ssd_mul #(
  parameter int WA = 8,
  parameter int WB = 8
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] prod
);

  localparam int HA = WA / 2;
  localparam int HB = WB / 2;
  localparam int PW = WA + WB;

  logic        [HA-1:0]    al;
  logic signed [WA-HA-1:0] ah;
  logic        [HB-1:0]    bl;
  logic signed [WB-HB-1:0] bh;

  logic signed [PW-1:0] ll_r, lh_r, hl_r, hh_r;
  logic signed [PW-1:0] prod_r;

  assign al = a[HA-1:0];
  assign ah = a[WA-1:HA];
  assign bl = b[HB-1:0];
  assign bh = b[WB-1:HB];

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r   <= PW'($signed({1'b0, al}) * $signed({1'b0, bl}));
      lh_r   <= PW'($signed({1'b0, al}) * bh);
      hl_r   <= PW'(ah * $signed({1'b0, bl}));
      hh_r   <= PW'(ah * bh);
      prod_r <= (hh_r <<< (HA + HB)) + (hl_r <<< HA) + (lh_r <<< HB) + ll_r;
    end
  end

  assign prod = prod_r;

endmodule

/* rtl/ssd_div.sv */
// ---------------------------------------------------------------------------
// ssd_div
// clamped fraction num/den in [0,1], one quotient bit per stage
// ---------------------------------------------------------------------------
module ssd_div #(
  parameter int W = 8,
  parameter int P = 4
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  output logic        [P:0]   quo
);

  logic [W-1:0] rem_r   [P+1];
  logic [W-1:0] den_r   [P+1];
  logic [P:0]   q_r     [P+1];
  logic [P:0]   done_r;

  logic [W-1:0] rem_nxt [P+1];
  logic [W-1:0] den_nxt [P+1];
  logic [P:0]   q_nxt   [P+1];
  logic [P:0]   done_nxt;
  logic [W-1:0] sh      [P+1];

  always_comb begin
    rem_nxt[0]  = W'(num);
    den_nxt[0]  = W'(den);
    q_nxt[0]    = '0;
    done_nxt[0] = 1'b0;
    sh[0]       = '0;
    if (num[W-1] || num == '0) begin
      done_nxt[0] = 1'b1;
    end else if (num >= den) begin
      done_nxt[0] = 1'b1;
      q_nxt[0]    = {1'b1, {P{1'b0}}};
    end
    for (int k = 1; k <= P; k++) begin
      den_nxt[k]  = den_r[k-1];
      done_nxt[k] = done_r[k-1];
      sh[k]       = {rem_r[k-1][W-2:0], 1'b0};
      rem_nxt[k]  = rem_r[k-1];
      q_nxt[k]    = q_r[k-1];
      if (!done_r[k-1]) begin
        if (sh[k] >= den_r[k-1]) begin
          rem_nxt[k] = sh[k] - den_r[k-1];
          q_nxt[k]   = {q_r[k-1][P-1:0], 1'b1};
        end else begin
          rem_nxt[k] = sh[k];
          q_nxt[k]   = {q_r[k-1][P-1:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= P; k++) begin
        rem_r[k]  <= rem_nxt[k];
        den_r[k]  <= den_nxt[k];
        q_r[k]    <= q_nxt[k];
        done_r[k] <= done_nxt[k];
      end
    end
  end

  assign quo = q_r[P];

endmodule

/* bench/tb_segment_segment_closest_distance.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_segment_segment_closest_distance
// streams segment pairs through the block under random idling on both
// channels, predicts each squared distance with exact wide arithmetic and
// compares results in order; the degenerate threshold is rewritten between
// phases while the pipeline is empty
// ---------------------------------------------------------------------------
module tb_segment_segment_closest_distance;
  import ssd_pkg::*;

  localparam int CB = 24;
  localparam int PF = 16;
  localparam int LAT = 17 + 2 * PF;
  localparam int WD = 256;
  localparam int STALL_LIMIT = 5000;

  typedef logic signed [WD-1:0] wide_t;
  typedef logic signed [CB-1:0] coord_t;
  typedef struct packed {
    coord_t pfx, pfy, pfz, pbx, pby, pbz, qfx, qfy, qfz, qbx, qby, qbz;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ssd_in_if #(.CB(CB)) in_bus ();
  ssd_out_if out_bus ();
  ssd_cfg_if cfg_bus ();

  segment_segment_closest_distance #(.COORD_BITS(CB), .PARAM_FRAC_BITS(PF)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus), .cfg_bus(cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pair_t pending_pairs[$];
  dist_t expected_dist[$];
  thr_t threshold = '0;
  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;
  int quiet_cycles = 0;
  bit cfg_pending = 1'b0;
  thr_t cfg_value;

  function automatic wide_t frac_quot(wide_t num, wide_t den);
    wide_t rem;
    wide_t q;
    if (num <= 0) return 0;
    if (num >= den) return wide_t'(1) <<< PF;
    rem = num;
    q = 0;
    for (int i = 0; i < PF; i++) begin
      rem = rem <<< 1;
      q = q <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic dist_t closest_dist(pair_t p, thr_t thr);
    wide_t d1[3], d2[3], r[3];
    wide_t a, e, f, c, b, den, tnum, s, t, w, acc;
    bit adeg, edeg;
    d1[0] = p.pfx - p.pbx; d1[1] = p.pfy - p.pby; d1[2] = p.pfz - p.pbz;
    d2[0] = p.qfx - p.qbx; d2[1] = p.qfy - p.qby; d2[2] = p.qfz - p.qbz;
    r[0] = p.pbx - p.qbx; r[1] = p.pby - p.qby; r[2] = p.pbz - p.qbz;
    a = 0; e = 0; f = 0; c = 0; b = 0; s = 0; t = 0;
    for (int k = 0; k < 3; k++) begin
      a += d1[k] * d1[k];
      e += d2[k] * d2[k];
      f += d2[k] * r[k];
      c += d1[k] * r[k];
      b += d1[k] * d2[k];
    end
    adeg = a <= wide_t'(thr);
    edeg = e <= wide_t'(thr);
    if (adeg && edeg) begin
      s = 0;
    end else if (adeg) begin
      t = frac_quot(f, e);
    end else if (edeg) begin
      s = frac_quot(-c, a);
    end else begin
      den = a * e - b * b;
      if (den != 0) s = frac_quot(b * f - c * e, den);
      tnum = b * s + (f <<< PF);
      if (tnum < 0) begin
        t = 0;
        s = frac_quot(-c, a);
      end else if (tnum > (e <<< PF)) begin
        t = wide_t'(1) <<< PF;
        s = frac_quot(b - c, a);
      end else begin
        t = frac_quot(tnum, e <<< PF);
      end
    end
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      w = (r[k] <<< PF) + d1[k] * s - d2[k] * t;
      acc += w * w;
    end
    acc = acc >>> (2 * PF);
    if (acc >= (wide_t'(1) <<< OUT_W)) return '1;
    return acc[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      cfg_bus.valid <= 1'b0;
      cfg_bus.degenerate_threshold <= '0;
      {in_bus.first_far_x, in_bus.first_far_y, in_bus.first_far_z,
       in_bus.first_base_x, in_bus.first_base_y, in_bus.first_base_z,
       in_bus.second_far_x, in_bus.second_far_y, in_bus.second_far_z,
       in_bus.second_base_x, in_bus.second_base_y, in_bus.second_base_z} <= '0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        threshold = cfg_bus.degenerate_threshold;
        cfg_bus.valid <= 1'b0;
      end else if (cfg_pending && !cfg_bus.valid) begin
        cfg_bus.valid <= 1'b1;
        cfg_bus.degenerate_threshold <= cfg_value;
        cfg_pending = 1'b0;
      end
      if (in_bus.valid && in_bus.ready) begin
        expected_dist.push_back(closest_dist({in_bus.first_far_x, in_bus.first_far_y,
          in_bus.first_far_z, in_bus.first_base_x, in_bus.first_base_y,
          in_bus.first_base_z, in_bus.second_far_x, in_bus.second_far_y,
          in_bus.second_far_z, in_bus.second_base_x, in_bus.second_base_y,
          in_bus.second_base_z}, threshold));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle) begin
          pair_t p;
          p = pending_pairs.pop_front();
          in_bus.valid <= 1'b1;
          {in_bus.first_far_x, in_bus.first_far_y, in_bus.first_far_z,
           in_bus.first_base_x, in_bus.first_base_y, in_bus.first_base_z,
           in_bus.second_far_x, in_bus.second_far_y, in_bus.second_far_z,
           in_bus.second_base_x, in_bus.second_base_y, in_bus.second_base_z} <= p;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_dist.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0h", out_bus.squared_distance));
        end else begin
          dist_t want;
          want = expected_dist.pop_front();
          if (out_bus.squared_distance !== want)
            report_mismatch($sformatf("squared_distance got %0h want %0h",
              out_bus.squared_distance, want));
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_idle);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready) ||
          (pending_pairs.size() == 0 && expected_dist.size() == 0 && !in_bus.valid &&
           !cfg_pending && !cfg_bus.valid))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_segment_segment_closest_distance: FAIL");
        $finish;
      end
    end
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(4000)) - 2000);
      default: return coord_t'($signed($urandom_range(200)) - 100);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(2);
    p = {12{coord_t'(0)}};
    p.pfx = rand_coord(mode); p.pfy = rand_coord(mode); p.pfz = rand_coord(mode);
    p.pbx = rand_coord(mode); p.pby = rand_coord(mode); p.pbz = rand_coord(mode);
    p.qfx = rand_coord(mode); p.qfy = rand_coord(mode); p.qfz = rand_coord(mode);
    p.qbx = rand_coord(mode); p.qby = rand_coord(mode); p.qbz = rand_coord(mode);
    case ($urandom_range(7))
      0: {p.pfx, p.pfy, p.pfz} = {p.pbx, p.pby, p.pbz};
      1: {p.qfx, p.qfy, p.qfz} = {p.qbx + coord_t'($urandom_range(3)), p.qby, p.qbz};
      2: begin
        p.qfx = p.qbx + (p.pfx - p.pbx);
        p.qfy = p.qby + (p.pfy - p.pby);
        p.qfz = p.qbz + (p.pfz - p.pbz);
      end
      3: begin
        {p.pfx, p.pfy, p.pfz} = {p.pbx, p.pby, p.pbz};
        {p.qfx, p.qfy, p.qfz} = {p.qbx, p.qby, p.qbz};
      end
      default: ;
    endcase
    return p;
  endfunction

  // sampled away from the rising edge so driver updates have settled
  task automatic drain();
    @(negedge clk);
    while (pending_pairs.size() > 0 || expected_dist.size() > 0 || in_bus.valid)
      @(negedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  task automatic write_threshold(thr_t v);
    cfg_value = v;
    cfg_pending = 1'b1;
    @(negedge clk);
    while (cfg_pending || cfg_bus.valid) @(negedge clk);
  endtask

  task automatic run_phase(int n, int s_idle, int r_idle, thr_t thr);
    write_threshold(thr);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < n; i++) pending_pairs.push_back(rand_pair());
    drain();
  endtask

  initial begin
    pair_t p;
    coord_t mx, mn;
    mx = coord_t'(24'h7fffff);
    mn = coord_t'(24'h800000);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, degenerate, parallel, crossing, clamped ends
    pending_pairs.push_back({12{mx}});
    pending_pairs.push_back({12{mn}});
    pending_pairs.push_back({mx, mx, mx, mn, mn, mn, mn, mn, mn, mx, mx, mx});
    pending_pairs.push_back({mx, mx, mx, mn, mn, mn, mx, mn, mx, mn, mx, mn});
    pending_pairs.push_back({mx, mx, mx, mx, mx, mx, mn, mn, mn, mn, mn, mn});
    pending_pairs.push_back({12{coord_t'(0)}});
    p = {12{coord_t'(0)}}; p.pfx = 256; p.qfx = 512; p.qbx = 256; p.qby = 256;
    pending_pairs.push_back(p);
    p = {12{coord_t'(0)}}; p.pfx = 256; p.qfy = 256; p.qby = -256; p.qbx = 128;
    p.qfx = 128; p.qbz = 64; p.qfz = 64;
    pending_pairs.push_back(p);
    p = {12{coord_t'(0)}}; p.pfx = 256; p.qbx = 1024; p.qfx = 2048; p.qfy = 100;
    pending_pairs.push_back(p);
    p = {12{coord_t'(0)}}; p.pfx = 256; p.qbx = -1024; p.qfx = -512; p.qby = 30;
    pending_pairs.push_back(p);
    p = {12{coord_t'(0)}}; p.pfx = 256; p.qbx = 100; p.qby = 500; p.qfx = 100;
    p.qfy = 300;
    pending_pairs.push_back(p);
    p = {12{coord_t'(0)}}; p.pfx = 256; p.qbx = 100; p.qby = -500; p.qfx = 100;
    p.qfy = -300;
    pending_pairs.push_back(p);
    p = {12{coord_t'(0)}}; p.qfx = 1; p.pbx = 5;
    pending_pairs.push_back(p);
    drain();
    write_threshold('1);
    pending_pairs.push_back(p);
    p = {12{coord_t'(0)}}; p.pfx = 4; p.qbx = 2000; p.qfx = 3000; p.qfy = 900;
    pending_pairs.push_back(p);
    p = {12{coord_t'(0)}}; p.qfx = 4; p.pbx = 2000; p.pfx = 3000; p.pfy = 900;
    pending_pairs.push_back(p);
    p = {12{coord_t'(0)}}; p.pfx = 1023; p.qfx = 1024; p.qby = 77;
    pending_pairs.push_back(p);
    drain();

    run_phase(420, 30, 70, '0);
    run_phase(420, 70, 30, thr_t'($urandom_range(5000)));
    run_phase(440, 0, 0, thr_t'($urandom));

    if (errors == 0) begin
      $display("tb_segment_segment_closest_distance: PASS");
    end else begin
      $display("tb_segment_segment_closest_distance: FAIL");
    end
    $finish;
  end
endmodule
